@@ hw/rtl/peu_pkg.sv @@
`timescale 1ns / 1ps

package peu_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_GRAVITY_X  = 8'd0;
  localparam logic [7:0] REG_GRAVITY_Y  = 8'd1;
  localparam logic [7:0] REG_GRAVITY_Z  = 8'd2;
  localparam logic [7:0] REG_FRAME_TIME = 8'd3;

  localparam logic signed [31:0] GRAVITY_X_RST  = 32'sd0;
  localparam logic signed [31:0] GRAVITY_Y_RST  = -32'sd642253;
  localparam logic signed [31:0] GRAVITY_Z_RST  = 32'sd0;
  localparam logic [16:0]        FRAME_TIME_RST = 17'd1092;

  localparam logic signed [31:0] EXPIRED_LIFE = -32'sd65536;
  localparam logic [16:0]        ALPHA_ONE    = 17'd65536;

  localparam int NUM_STAGES = 19;
  localparam int DIV_FIRST  = 3;
  localparam int QUO_BITS   = 16;

  typedef enum logic [1:0] {
    AM_ZERO,
    AM_ONE,
    AM_DIV
  } alpha_mode_e;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][51:0] acc;
    logic [19:0]      fac;
    logic [31:0]      life;
    logic             live;
    logic             last;
    alpha_mode_e      amode;
    logic [51:0]      rem;
    logic [32:0]      den;
    logic [15:0]      quo;
  } stage_t;

endpackage

@@ hw/rtl/particle_euler_update_unit.sv @@
`timescale 1ns / 1ps

// Particle Euler update: one particle record in, the same particle advanced
// by one frame out. Input beats arrive on in_valid_i/in_ready_o, results
// leave on out_valid_o/out_ready_i, and the configuration port
// (cfg_valid_i, cfg_index_i, cfg_data_i) is always ready and writes gravity
// and frame time; indexes beyond the register list are ignored.
// Configuration must only be written while no particle is in flight.
// The pipeline has 19 register stages and the first one loads at the accepting
// edge; one beat is accepted every cycle while the receiver does not stall.
// The depth is set by the alpha divider, which retires one quotient bit per
// stage; the three kinematic multiplies run alongside it in the first stages.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the default gravity and frame time.
module particle_euler_update_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [16:0] damping_i,
  input  logic signed [31:0] life_now_i,
  input  logic [30:0] life_max_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic signed [31:0] new_life_o,
  output logic [16:0] alpha_o,
  output logic        alive_o,
  output logic        last_out_o
);

  localparam int LAST = peu_pkg::NUM_STAGES - 1;

  logic [2:0][31:0] grav_q;
  logic [16:0]      dt_q;

  peu_pkg::stage_t pipe_q [peu_pkg::NUM_STAGES];
  peu_pkg::stage_t pipe_d [peu_pkg::NUM_STAGES];
  logic [peu_pkg::NUM_STAGES-1:0] vld_q;
  logic en;

  // Round a Q20.32 product to Q21.16, nearest with ties toward +inf.
  function automatic logic signed [36:0] rnd16(input logic signed [51:0] p);
    logic signed [52:0] t;
    t = {p[51], p} + 53'sd32768;
    return t[52:16];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= peu_pkg::GRAVITY_X_RST;
      grav_q[1] <= peu_pkg::GRAVITY_Y_RST;
      grav_q[2] <= peu_pkg::GRAVITY_Z_RST;
      dt_q      <= peu_pkg::FRAME_TIME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        peu_pkg::REG_GRAVITY_X:  grav_q[0] <= cfg_data_i;
        peu_pkg::REG_GRAVITY_Y:  grav_q[1] <= cfg_data_i;
        peu_pkg::REG_GRAVITY_Z:  grav_q[2] <= cfg_data_i;
        peu_pkg::REG_FRAME_TIME: dt_q      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign en          = !vld_q[LAST] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAST];

  always_comb begin
    peu_pkg::stage_t s;
    logic signed [17:0] dt_s;
    logic signed [32:0] life_dif;
    logic [30:0] l_val;
    logic [30:0] m_val;
    logic [34:0] l10;
    logic [34:0] m9;
    logic [34:0] m3;
    logic [51:0] rd;
    logic [34:0] n10;
    logic [51:0] dsh;
    int b;

    dt_s = $signed({1'b0, dt_q});

    // Stage 0: gravity and damping products, life countdown.
    s = '0;
    s.pos[0] = pos_x_i;
    s.pos[1] = pos_y_i;
    s.pos[2] = pos_z_i;
    s.vel[0] = vel_x_i;
    s.vel[1] = vel_y_i;
    s.vel[2] = vel_z_i;
    for (int i = 0; i < 3; i++) begin
      s.acc[i] = 52'($signed(grav_q[i]) * dt_s);
    end
    s.rem  = 52'(damping_i * dt_q);
    s.den  = {2'b0, life_max_i};
    s.last = is_last_i;
    s.life = life_now_i;
    life_dif = {life_now_i[31], life_now_i} - $signed({16'b0, dt_q});
    if (!life_now_i[31]) begin
      if (life_dif > 33'sd0) begin
        s.live = 1'b1;
        s.life = life_dif[31:0];
      end else begin
        s.life = peu_pkg::EXPIRED_LIFE;
      end
    end
    pipe_d[0] = s;

    for (int k = 1; k < peu_pkg::NUM_STAGES; k++) begin
      s = pipe_q[k-1];
      if (k == 1) begin
        // Apply gravity, form the damping factor and pick the alpha branch.
        rd    = (pipe_q[k-1].rem + 52'd32768) >> 16;
        s.fac = 20'sd65536 - $signed(rd[19:0]);
        if (pipe_q[k-1].live) begin
          for (int i = 0; i < 3; i++) begin
            s.vel[i] = sat32(38'($signed(pipe_q[k-1].vel[i]))
                             + 38'(rnd16($signed(pipe_q[k-1].acc[i]))));
          end
        end
        l_val = pipe_q[k-1].life[30:0];
        m_val = pipe_q[k-1].den[30:0];
        l10   = ({4'b0, l_val} << 3) + ({4'b0, l_val} << 1);
        m9    = ({4'b0, m_val} << 3) + {4'b0, m_val};
        m3    = ({4'b0, m_val} << 1) + {4'b0, m_val};
        s.rem = '0;
        if (!pipe_q[k-1].live) begin
          s.amode = peu_pkg::AM_ZERO;
        end else if (l10 > m9) begin
          if (m_val == 31'd0 || l_val >= m_val) begin
            s.amode = peu_pkg::AM_ZERO;
          end else begin
            s.amode = peu_pkg::AM_DIV;
            s.rem   = 52'(m_val - l_val);
            s.den   = {2'b0, m_val};
          end
        end else if (l10 < m3) begin
          s.amode = peu_pkg::AM_DIV;
          s.rem   = 52'(l_val);
          s.den   = m3[32:0];
        end else begin
          s.amode = peu_pkg::AM_ONE;
        end
      end else if (k == 2) begin
        for (int i = 0; i < 3; i++) begin
          s.acc[i] = 52'($signed(pipe_q[k-1].vel[i]) * $signed(pipe_q[k-1].fac));
        end
        // Numerator times 655360 is times ten, then a 16-bit shift.
        n10   = (35'(pipe_q[k-1].rem) << 3) + (35'(pipe_q[k-1].rem) << 1);
        s.rem = {1'b0, n10, 16'b0};
      end else begin
        if (k == 3 && pipe_q[k-1].live) begin
          for (int i = 0; i < 3; i++) begin
            s.vel[i] = sat32(38'(rnd16($signed(pipe_q[k-1].acc[i]))));
          end
        end
        if (k == 4) begin
          for (int i = 0; i < 3; i++) begin
            s.acc[i] = 52'($signed(pipe_q[k-1].vel[i]) * dt_s);
          end
        end
        if (k == 5 && pipe_q[k-1].live) begin
          for (int i = 0; i < 3; i++) begin
            s.pos[i] = sat32(38'($signed(pipe_q[k-1].pos[i]))
                             + 38'(rnd16($signed(pipe_q[k-1].acc[i]))));
          end
        end
        // One restoring divide step per stage, most significant bit first.
        b   = peu_pkg::DIV_FIRST + peu_pkg::QUO_BITS - 1 - k;
        dsh = 52'(pipe_q[k-1].den) << b;
        if (pipe_q[k-1].rem >= dsh) begin
          s.rem    = pipe_q[k-1].rem - dsh;
          s.quo[b] = 1'b1;
        end
      end
      pipe_d[k] = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[peu_pkg::NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < peu_pkg::NUM_STAGES; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign new_pos_x_o = pipe_q[LAST].pos[0];
  assign new_pos_y_o = pipe_q[LAST].pos[1];
  assign new_pos_z_o = pipe_q[LAST].pos[2];
  assign new_vel_x_o = pipe_q[LAST].vel[0];
  assign new_vel_y_o = pipe_q[LAST].vel[1];
  assign new_vel_z_o = pipe_q[LAST].vel[2];
  assign new_life_o  = pipe_q[LAST].life;
  assign alive_o     = pipe_q[LAST].live;
  assign last_out_o  = pipe_q[LAST].last;

  always_comb begin
    case (pipe_q[LAST].amode)
      peu_pkg::AM_DIV: alpha_o = {1'b0, pipe_q[LAST].quo};
      peu_pkg::AM_ONE: alpha_o = peu_pkg::ALPHA_ONE;
      default:         alpha_o = '0;
    endcase
  end

endmodule
